// File: rtl/core/jlrf_pkg.sv
`timescale 1ns / 1ps
package jlrf_pkg;

  localparam int unsigned PeriodQ16 = 655;
  localparam logic signed [33:0] PiQ16 = 34'sd205887;
  localparam logic signed [33:0] TwoPiQ16 = 34'sd411775;
  localparam int unsigned NumLanes = 4;

  typedef enum logic [2:0] {
    REG_OMEGA_SQ  = 3'd0,
    REG_DAMPING   = 3'd1,
    REG_POS_JERK  = 3'd2,
    REG_POS_ACC   = 3'd3,
    REG_POS_VEL   = 3'd4,
    REG_YAW_JERK  = 3'd5,
    REG_YAW_ACC   = 3'd6,
    REG_YAW_VEL   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_ACC,
    ST_AMUL,
    ST_VEL,
    ST_VMUL,
    ST_POS,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] target_yaw;
    logic               tracking;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] start_yaw;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic signed [31:0] out_acc_x;
    logic signed [31:0] out_acc_y;
    logic signed [31:0] out_acc_z;
    logic signed [31:0] out_yaw;
    logic signed [31:0] out_yaw_rate;
  } out_beat_t;

  typedef struct packed {
    logic [30:0] jerk_step;
    logic [30:0] acc_max;
    logic [30:0] vel_max;
  } lane_lim_t;

  typedef struct packed {
    logic load;
    logic st_acc;
    logic st_amul;
    logic st_vel;
    logic st_vmul;
    logic st_pos;
  } lane_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [49:0] clampmag(input logic signed [49:0] v,
                                                  input logic [30:0] lim);
    logic signed [49:0] l;
    l = $signed({19'b0, lim});
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

endpackage

// File: rtl/core/jlrf_mul.sv
`timescale 1ns / 1ps
module jlrf_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic        [30:0] b,
  output logic signed [48:0] p
);

  logic signed [64:0] prod;

  // floor(a*b/65536) via arithmetic shift
  always_ff @(posedge clk) begin
    prod <= a * $signed({1'b0, b});
  end

  assign p = prod[64:16];

endmodule

// File: rtl/core/jlrf_lane.sv
`timescale 1ns / 1ps
module jlrf_lane #(
  parameter int unsigned PERIOD = jlrf_pkg::PeriodQ16
) (
  input  logic                clk,
  input  logic                rst,
  input  jlrf_pkg::lane_ctl_t ctl,
  input  logic signed [31:0]  err,
  input  logic signed [31:0]  start,
  input  logic        [30:0]  omega_sq,
  input  logic        [30:0]  damping,
  input  jlrf_pkg::lane_lim_t lim,
  output logic signed [31:0]  pos,
  output logic signed [31:0]  vel,
  output logic signed [31:0]  acc
);

  logic signed [32:0] ma_a;
  logic signed [32:0] mb_a;
  logic        [30:0] ma_b;
  logic        [30:0] mb_b;
  logic signed [48:0] pa;
  logic signed [48:0] pb;
  logic signed [49:0] want;
  logic signed [49:0] delta;
  logic signed [49:0] acc_next;
  logic signed [49:0] vel_next;

  always_comb begin
    ma_a = 33'(err);
    mb_a = 33'(vel);
    ma_b = omega_sq;
    mb_b = damping;
    if (ctl.st_amul) begin
      ma_a = 33'(acc);
      ma_b = 31'(PERIOD);
    end else if (ctl.st_vmul) begin
      ma_a = 33'(vel);
      ma_b = 31'(PERIOD);
    end
  end

  jlrf_mul u_ma (.clk(clk), .a(ma_a), .b(ma_b), .p(pa));
  jlrf_mul u_mb (.clk(clk), .a(mb_a), .b(mb_b), .p(pb));

  always_comb begin
    want = 50'(pa) - 50'(pb);
    delta = jlrf_pkg::clampmag(want - 50'(acc), lim.jerk_step);
    acc_next = jlrf_pkg::clampmag(50'(acc) + delta, lim.acc_max);
    vel_next = jlrf_pkg::clampmag(50'(vel) + 50'(pa), lim.vel_max);
  end

  // err: products in flight; acc: take new acc; amul: acc*T in flight;
  // vel: take new vel; vmul: vel*T in flight; pos: integrate
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
      acc <= '0;
    end else if (ctl.load) begin
      pos <= start;
      vel <= '0;
      acc <= '0;
    end else if (ctl.st_acc) begin
      acc <= acc_next[31:0];
    end else if (ctl.st_vel) begin
      vel <= vel_next[31:0];
    end else if (ctl.st_pos) begin
      pos <= jlrf_pkg::sat32(34'(pos) + $signed(pa[33:0]));
    end
  end

endmodule

// File: rtl/core/jerk_limited_reference_filter_top.sv
`timescale 1ns / 1ps
// Init beat: IDLE, OUT, then registered output; advance beat: IDLE, ERR, ACC,
// AMUL, VEL, VMUL, POS, OUT, then registered output. One beat in flight: a new
// beat is taken only in IDLE, and not while a held output is stalled.
// Four lanes (x, y, z, yaw), each time-sharing its own two 33x31 multipliers over the tick.
// Reset (rst, synchronous): state zero, registers to defaults, output empty.
module jerk_limited_reference_filter_top #(
  parameter int unsigned PERIOD = jlrf_pkg::PeriodQ16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  jlrf_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jlrf_pkg::out_beat_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  jlrf_pkg::state_t state;
  jlrf_pkg::state_t state_next;
  jlrf_pkg::in_beat_t req;
  logic [30:0] regs [8];
  logic signed [31:0] err [4];
  logic signed [31:0] start [4];
  logic signed [31:0] pos [4];
  logic signed [31:0] vel [4];
  logic signed [31:0] acc [4];
  logic signed [33:0] eyaw;
  jlrf_pkg::lane_ctl_t ctl;
  logic take;

  assign take = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      jlrf_pkg::ST_IDLE: if (take) begin
        state_next = in_data.req_type ? jlrf_pkg::ST_OUT : jlrf_pkg::ST_ERR;
      end
      jlrf_pkg::ST_ERR: state_next = jlrf_pkg::ST_ACC;
      jlrf_pkg::ST_ACC: state_next = jlrf_pkg::ST_AMUL;
      jlrf_pkg::ST_AMUL: state_next = jlrf_pkg::ST_VEL;
      jlrf_pkg::ST_VEL: state_next = jlrf_pkg::ST_VMUL;
      jlrf_pkg::ST_VMUL: state_next = jlrf_pkg::ST_POS;
      jlrf_pkg::ST_POS: state_next = jlrf_pkg::ST_OUT;
      jlrf_pkg::ST_OUT: if (!out_valid || !out_stall) begin
        state_next = jlrf_pkg::ST_IDLE;
      end
      default: state_next = jlrf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != jlrf_pkg::ST_IDLE) || (out_valid && out_stall);
    ctl.load = take && in_data.req_type;
    ctl.st_acc = (state == jlrf_pkg::ST_ACC);
    ctl.st_amul = (state == jlrf_pkg::ST_AMUL);
    ctl.st_vel = (state == jlrf_pkg::ST_VEL);
    ctl.st_vmul = (state == jlrf_pkg::ST_VMUL);
    ctl.st_pos = (state == jlrf_pkg::ST_POS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jlrf_pkg::ST_IDLE;
      out_valid <= 1'b0;
      regs[jlrf_pkg::REG_OMEGA_SQ] <= 31'd65536;
      regs[jlrf_pkg::REG_DAMPING] <= 31'd131072;
      regs[jlrf_pkg::REG_POS_JERK] <= 31'd65536;
      regs[jlrf_pkg::REG_POS_ACC] <= 31'd65536;
      regs[jlrf_pkg::REG_POS_VEL] <= 31'd65536;
      regs[jlrf_pkg::REG_YAW_JERK] <= 31'd65536;
      regs[jlrf_pkg::REG_YAW_ACC] <= 31'd65536;
      regs[jlrf_pkg::REG_YAW_VEL] <= 31'd65536;
    end else begin
      state <= state_next;
      if (cfg_valid) regs[cfg_index] <= cfg_data;
      if (state == jlrf_pkg::ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) req <= in_data;
    if (state == jlrf_pkg::ST_OUT && (!out_valid || !out_stall)) begin
      out_data.out_pos_x <= pos[0];
      out_data.out_pos_y <= pos[1];
      out_data.out_pos_z <= pos[2];
      out_data.out_vel_x <= vel[0];
      out_data.out_vel_y <= vel[1];
      out_data.out_vel_z <= vel[2];
      out_data.out_acc_x <= acc[0];
      out_data.out_acc_y <= acc[1];
      out_data.out_acc_z <= acc[2];
      out_data.out_yaw <= pos[3];
      out_data.out_yaw_rate <= vel[3];
    end
  end

  always_comb begin
    err[0] = req.tracking ? jlrf_pkg::sat32(34'(req.target_x) - 34'(pos[0])) : '0;
    err[1] = req.tracking ? jlrf_pkg::sat32(34'(req.target_y) - 34'(pos[1])) : '0;
    err[2] = req.tracking ? jlrf_pkg::sat32(34'(req.target_z) - 34'(pos[2])) : '0;
    eyaw = 34'(req.target_yaw) - 34'(pos[3]);
    if (eyaw > jlrf_pkg::PiQ16) eyaw = eyaw - jlrf_pkg::TwoPiQ16;
    else if (eyaw < -jlrf_pkg::PiQ16) eyaw = eyaw + jlrf_pkg::TwoPiQ16;
    err[3] = jlrf_pkg::sat32(eyaw);
    start[0] = in_data.start_x;
    start[1] = in_data.start_y;
    start[2] = in_data.start_z;
    start[3] = in_data.start_yaw;
  end

  for (genvar g = 0; g < jlrf_pkg::NumLanes; g++) begin : g_lane
    jlrf_pkg::lane_lim_t lim;
    assign lim.jerk_step = (g == 3) ? regs[jlrf_pkg::REG_YAW_JERK] : regs[jlrf_pkg::REG_POS_JERK];
    assign lim.acc_max = (g == 3) ? regs[jlrf_pkg::REG_YAW_ACC] : regs[jlrf_pkg::REG_POS_ACC];
    assign lim.vel_max = (g == 3) ? regs[jlrf_pkg::REG_YAW_VEL] : regs[jlrf_pkg::REG_POS_VEL];
    jlrf_lane #(.PERIOD(PERIOD)) u_lane (
      .clk(clk), .rst(rst), .ctl(ctl), .err(err[g]), .start(start[g]),
      .omega_sq(regs[jlrf_pkg::REG_OMEGA_SQ]), .damping(regs[jlrf_pkg::REG_DAMPING]),
      .lim(lim), .pos(pos[g]), .vel(vel[g]), .acc(acc[g])
    );
  end

endmodule
